@@ rtl/vicd_pkg.sv @@
// Shared types and constants for the vector interface command decoder.
// Depends on nothing; every other file in the block imports it.
package vicd_pkg;

   // Command opcodes of a code word.
   localparam logic [6:0] CMD_NOP      = 7'h00;
   localparam logic [6:0] CMD_STCYCL   = 7'h01;
   localparam logic [6:0] CMD_OFFSET   = 7'h02;
   localparam logic [6:0] CMD_BASE     = 7'h03;
   localparam logic [6:0] CMD_ITOP     = 7'h04;
   localparam logic [6:0] CMD_STMOD    = 7'h05;
   localparam logic [6:0] CMD_MSKPATH3 = 7'h06;
   localparam logic [6:0] CMD_MARK     = 7'h07;
   localparam logic [6:0] CMD_FLUSHE   = 7'h10;
   localparam logic [6:0] CMD_FLUSH    = 7'h11;
   localparam logic [6:0] CMD_FLUSHA   = 7'h13;
   localparam logic [6:0] CMD_MSCAL    = 7'h14;
   localparam logic [6:0] CMD_MSCALF   = 7'h15;
   localparam logic [6:0] CMD_MSCNT    = 7'h17;
   localparam logic [6:0] CMD_STMASK   = 7'h20;
   localparam logic [6:0] CMD_STROW    = 7'h30;
   localparam logic [6:0] CMD_STCOL    = 7'h31;
   localparam logic [6:0] CMD_MPG      = 7'h4a;
   localparam logic [6:0] CMD_DIRECT   = 7'h50;
   localparam logic [6:0] CMD_DIRECTHL = 7'h51;
   // Codes in the unpack range that are not unpack formats.
   localparam logic [6:0] CMD_UNPK_GAP0 = 7'h67;
   localparam logic [6:0] CMD_UNPK_GAP1 = 7'h77;
   localparam logic [6:0] CMD_UNPK_GAP2 = 7'h7b;

   // Configuration register indexes.
   localparam logic CSR_UNIT_SELECT = 1'b0;
   localparam logic CSR_MASK_ERRORS = 1'b1;

   // Transfer lengths and address masks.
   localparam logic [18:0] MPG_WORDS_MAX    = 19'd512;
   localparam logic [18:0] DIRECT_WORDS_MAX = 19'h40000;
   localparam logic [18:0] ROWCOL_WORDS     = 19'd4;
   localparam logic [13:0] SMALL_ADDR_MASK  = 14'h0fff;

   // Result action codes.
   typedef enum logic [3:0] {
      ACT_NONE     = 4'd0,
      ACT_START    = 4'd1,
      ACT_CONTINUE = 4'd2,
      ACT_MICRO    = 4'd3,
      ACT_GIF      = 4'd4,
      ACT_UNPACK   = 4'd5,
      ACT_FLUSH    = 4'd6,
      ACT_ROW      = 4'd7,
      ACT_COL      = 4'd8,
      ACT_ERROR    = 4'd9,
      ACT_PATH3    = 4'd10
   } action_type;

   // One incoming request.
   typedef struct packed {
      logic        item_kind;
      logic [6:0]  command;
      logic [7:0]  count_field;
      logic [15:0] immediate;
      logic [31:0] data_word;
   } item_type;

   // Configuration seen by the decoder.
   typedef struct packed {
      logic unit_select;
      logic mask_errors;
   } cfg_type;

   // Architectural state of the decoder.
   typedef struct packed {
      logic [6:0]  pending_op;
      logic [18:0] words_left;
      logic [13:0] transfer_addr;
      logic [9:0]  base_reg;
      logic [9:0]  offset_reg;
      logic [10:0] tops_reg;
      logic [9:0]  itops_reg;
      logic [9:0]  itop_reg;
      logic [9:0]  top_reg;
      logic        dbf;
      logic        mark;
      logic        err;
      logic [15:0] cycle;
      logic [1:0]  mode;
      logic [31:0] mask;
   } state_type;

   // Per-request result fields that are not copies of state.
   typedef struct packed {
      action_type  action;
      logic [13:0] target_address;
      logic [31:0] out_word;
   } result_type;

endpackage

@@ rtl/vicd_decode.sv @@
// Single-pass decode of one request: next state and result fields.
// Depends on vicd_pkg; instantiated by the top level.
module vicd_decode
   import vicd_pkg::*;
#(
   parameter int MICRO_MEM_BYTES = 16384
) (
   input  item_type   item,
   input  cfg_type    cfg,
   input  state_type  state_cur,
   output state_type  state_nxt,
   output result_type result
);

   localparam logic [13:0] MicroAddrMask = 14'(MICRO_MEM_BYTES - 1);

   logic [13:0] addr_mask;
   logic        full;
   logic        unknown;
   logic        unpack;
   logic [9:0]  itops_cut;
   logic [18:0] words_dec;

   assign full      = cfg.unit_select;
   assign addr_mask = full ? MicroAddrMask : SMALL_ADDR_MASK;
   assign itops_cut = full ? state_cur.itops_reg : {2'b00, state_cur.itops_reg[7:0]};
   assign words_dec = state_cur.words_left - 19'd1;
   assign unpack    = (item.command[6:5] == 2'b11) && (item.command != CMD_UNPK_GAP0) &&
                      (item.command != CMD_UNPK_GAP1) && (item.command != CMD_UNPK_GAP2);

   always_comb begin
      state_nxt             = state_cur;
      result.action         = ACT_NONE;
      result.target_address = '0;
      result.out_word       = '0;
      unknown               = 1'b0;

      if (item.item_kind) begin
         // Data word for the pending transfer; ignored when nothing is pending.
         if (state_cur.words_left != '0) begin
            case (state_cur.pending_op)
               CMD_MPG: begin
                  result.action           = ACT_MICRO;
                  result.target_address   = state_cur.transfer_addr;
                  result.out_word         = item.data_word;
                  state_nxt.transfer_addr = (state_cur.transfer_addr + 14'd4) & addr_mask;
               end
               CMD_DIRECT, CMD_DIRECTHL: begin
                  result.action   = ACT_GIF;
                  result.out_word = item.data_word;
               end
               CMD_STROW, CMD_STCOL: begin
                  result.action = (state_cur.pending_op == CMD_STROW) ? ACT_ROW : ACT_COL;
                  result.target_address   = {12'd0, state_cur.transfer_addr[1:0]};
                  result.out_word         = item.data_word;
                  state_nxt.transfer_addr = {12'd0, state_cur.transfer_addr[1:0] + 2'd1};
               end
               default: begin
                  state_nxt.mask = item.data_word;
               end
            endcase
            state_nxt.words_left = words_dec;
            if (words_dec == '0) begin
               state_nxt.pending_op = CMD_NOP;
            end
         end
      end else begin
         // Code word: any pending transfer is dropped.
         state_nxt.pending_op = CMD_NOP;
         state_nxt.words_left = '0;
         case (item.command)
            CMD_NOP: ;
            CMD_STCYCL: state_nxt.cycle = item.immediate;
            CMD_OFFSET: begin
               if (!full) begin
                  unknown = 1'b1;
               end else begin
                  state_nxt.dbf        = 1'b0;
                  state_nxt.offset_reg = item.immediate[9:0];
                  state_nxt.tops_reg   = {1'b0, state_cur.base_reg};
               end
            end
            CMD_BASE: begin
               if (!full) begin
                  unknown = 1'b1;
               end else begin
                  state_nxt.base_reg = item.immediate[9:0];
               end
            end
            CMD_ITOP: state_nxt.itops_reg = item.immediate[9:0];
            CMD_STMOD: state_nxt.mode = item.immediate[1:0];
            CMD_MSKPATH3: begin
               if (!full) begin
                  unknown = 1'b1;
               end else begin
                  result.action   = ACT_PATH3;
                  result.out_word = {31'd0, item.immediate[15]};
               end
            end
            CMD_MARK: begin
               state_nxt.mark  = 1'b1;
               result.out_word = {16'd0, item.immediate};
            end
            CMD_FLUSHE: result.action = ACT_FLUSH;
            CMD_FLUSH, CMD_FLUSHA: begin
               if (!full) begin
                  unknown = 1'b1;
               end else begin
                  result.action = ACT_FLUSH;
               end
            end
            CMD_MSCAL, CMD_MSCALF, CMD_MSCNT: begin
               // Micro start or continue: load itop and, on the full unit, swap the buffers.
               state_nxt.itops_reg = itops_cut;
               state_nxt.itop_reg  = itops_cut;
               if (full) begin
                  state_nxt.top_reg = state_cur.tops_reg[9:0];
                  if (state_cur.dbf) begin
                     state_nxt.tops_reg = {1'b0, state_cur.base_reg};
                     state_nxt.dbf      = 1'b0;
                  end else begin
                     state_nxt.tops_reg = {1'b0, state_cur.base_reg} +
                                          {1'b0, state_cur.offset_reg};
                     state_nxt.dbf      = 1'b1;
                  end
               end
               if (item.command == CMD_MSCNT) begin
                  result.action = ACT_CONTINUE;
               end else begin
                  result.action         = ACT_START;
                  result.target_address = {item.immediate[10:0], 3'b000};
               end
            end
            CMD_STMASK: begin
               state_nxt.pending_op = item.command;
               state_nxt.words_left = 19'd1;
            end
            CMD_STROW, CMD_STCOL: begin
               state_nxt.pending_op    = item.command;
               state_nxt.words_left    = ROWCOL_WORDS;
               state_nxt.transfer_addr = '0;
            end
            CMD_MPG: begin
               state_nxt.pending_op    = item.command;
               state_nxt.words_left    = (item.count_field == '0) ? MPG_WORDS_MAX :
                                         {10'd0, item.count_field, 1'b0};
               state_nxt.transfer_addr = {item.immediate[10:0], 3'b000} & addr_mask;
            end
            CMD_DIRECT, CMD_DIRECTHL: begin
               if (!full) begin
                  unknown = 1'b1;
               end else begin
                  state_nxt.pending_op = item.command;
                  state_nxt.words_left = (item.immediate == '0) ? DIRECT_WORDS_MAX :
                                         {1'b0, item.immediate, 2'b00};
               end
            end
            default: begin
               if (unpack) begin
                  result.action   = ACT_UNPACK;
                  result.out_word = {1'b0, item.command, item.count_field, item.immediate};
               end else begin
                  unknown = 1'b1;
               end
            end
         endcase
         // Unknown commands raise the sticky error unless masked.
         if (unknown && !cfg.mask_errors) begin
            state_nxt.err = 1'b1;
            result.action = ACT_ERROR;
         end
      end
   end

endmodule

@@ rtl/vector_interface_command_decoder_unit.sv @@
// Top level of the vector interface command decoder.
// Depends on vicd_pkg and vicd_decode.
//
// One request can be accepted per clock cycle while req_stall is low. A request
// first lands in an input register; from there it is decoded in a single pass,
// and once the result register is free the decoder state is updated and the
// result is written to the result register. Each request
// yields exactly one result. The result register and input register form a
// two-entry pipeline: a stalled result holds back the input register, and
// req_stall rises only when both are full. Configuration is written through
// csr_write_enable, csr_index and csr_write_data and must only change while
// no request is in flight. MICRO_MEM_BYTES must be a power of two from 4096
// to 16384; micro memory addresses wrap at that size on the full unit and at
// 4096 bytes on the small unit.
module vector_interface_command_decoder_unit
   import vicd_pkg::*;
#(
   parameter int MICRO_MEM_BYTES = 16384
) (
   input  logic        clock,
   input  logic        reset,
   // Configuration port
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic        csr_write_data,
   // Request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_item_kind,
   input  logic [6:0]  req_command,
   input  logic [7:0]  req_count_field,
   input  logic [15:0] req_immediate,
   input  logic [31:0] req_data_word,
   // Result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_action,
   output logic [13:0] rsp_target_address,
   output logic [31:0] rsp_out_word,
   output logic [9:0]  rsp_itop_now,
   output logic [9:0]  rsp_top_now,
   output logic [10:0] rsp_tops_now,
   output logic        rsp_buffer_flag,
   output logic        rsp_mark_flag,
   output logic        rsp_error_flag,
   output logic [15:0] rsp_cycle_setting,
   output logic [1:0]  rsp_mode_setting,
   output logic [31:0] rsp_mask_setting
);

   cfg_type    cfg_ff;
   state_type  state_ff;
   state_type  state_in;
   item_type   item_ff;
   logic       item_valid_ff;
   result_type result_ff;
   result_type result_in;
   state_type  snap_ff;
   logic       rsp_valid_ff;
   logic       advance;
   logic       load;

   // Pipeline control: the decode stage moves when the result register frees.
   assign advance   = item_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign load      = !item_valid_ff || advance;
   assign req_stall = !load;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.unit_select <= 1'b1;
         cfg_ff.mask_errors <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_UNIT_SELECT: cfg_ff.unit_select <= csr_write_data;
            CSR_MASK_ERRORS: cfg_ff.mask_errors <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (load) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && req_valid) begin
         item_ff.item_kind   <= req_item_kind;
         item_ff.command     <= req_command;
         item_ff.count_field <= req_count_field;
         item_ff.immediate   <= req_immediate;
         item_ff.data_word   <= req_data_word;
      end
   end

   // Decode of the request held in the input register.
   vicd_decode #(
      .MICRO_MEM_BYTES(MICRO_MEM_BYTES)
   ) u_decode (
      .item      (item_ff),
      .cfg       (cfg_ff),
      .state_cur (state_ff),
      .state_nxt (state_in),
      .result    (result_in)
   );

   // Decoder state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Result register: per-request fields and a snapshot of the state after it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
         snap_ff   <= state_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_action         = result_ff.action;
   assign rsp_target_address = result_ff.target_address;
   assign rsp_out_word       = result_ff.out_word;
   assign rsp_itop_now       = snap_ff.itop_reg;
   assign rsp_top_now        = snap_ff.top_reg;
   assign rsp_tops_now       = snap_ff.tops_reg;
   assign rsp_buffer_flag    = snap_ff.dbf;
   assign rsp_mark_flag      = snap_ff.mark;
   assign rsp_error_flag     = snap_ff.err;
   assign rsp_cycle_setting  = snap_ff.cycle;
   assign rsp_mode_setting   = snap_ff.mode;
   assign rsp_mask_setting   = snap_ff.mask;

endmodule

@@ rtl/vicd_checker.sv @@
// Port-level checks for the vector interface command decoder, and its bind.
// Depends on vicd_pkg; attaches to vector_interface_command_decoder_unit.
module vicd_checker
   import vicd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [3:0]  rsp_action,
   input logic [13:0] rsp_target_address,
   input logic [31:0] rsp_out_word,
   input logic        rsp_error_flag
);

   logic err_seen_ff;

   // Remember that an error flag has been delivered since reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         err_seen_ff <= 1'b0;
      end else if (rsp_valid && !rsp_stall && rsp_error_flag) begin
         err_seen_ff <= 1'b1;
      end
   end

   // A stalled result stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // A stalled result keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_action) && $stable(rsp_out_word) &&
                                 $stable(rsp_target_address))
      else $error("result payload changed while stalled");

   // The error flag is sticky across results.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && err_seen_ff |-> rsp_error_flag)
      else $error("error flag cleared after being raised");

   // An error result always carries the error flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_action == ACT_ERROR) |-> rsp_error_flag)
      else $error("error action without error flag");

   // Row and column results index one of four registers.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_action == ACT_ROW) || (rsp_action == ACT_COL)) |->
         (rsp_target_address[13:2] == '0))
      else $error("row or column index out of range");

endmodule

bind vector_interface_command_decoder_unit vicd_checker u_vicd_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_action         (rsp_action),
   .rsp_target_address (rsp_target_address),
   .rsp_out_word       (rsp_out_word),
   .rsp_error_flag     (rsp_error_flag)
);

@@ test/tb_vicd_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the vector interface command decoder testbench.
// Watches the request, result and register ports, predicts each result and compares it.
// Depends on vicd_pkg for the command codes, register indexes and action codes.
module tb_vicd_checker
   import vicd_pkg::*;
#(
   parameter int MICRO_MEM_BYTES = 16384
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic        csr_write_data,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_item_kind,
   input  logic [6:0]  req_command,
   input  logic [7:0]  req_count_field,
   input  logic [15:0] req_immediate,
   input  logic [31:0] req_data_word,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [3:0]  rsp_action,
   input  logic [13:0] rsp_target_address,
   input  logic [31:0] rsp_out_word,
   input  logic [9:0]  rsp_itop_now,
   input  logic [9:0]  rsp_top_now,
   input  logic [10:0] rsp_tops_now,
   input  logic        rsp_buffer_flag,
   input  logic        rsp_mark_flag,
   input  logic        rsp_error_flag,
   input  logic [15:0] rsp_cycle_setting,
   input  logic [1:0]  rsp_mode_setting,
   input  logic [31:0] rsp_mask_setting,
   output int          mismatch_count,
   output int          results_pending,
   output int          results_checked,
   output logic [15:0] action_seen
);

   localparam logic [18:0] MASK_WORDS = 19'd1;

   // Everything one request is expected to produce.
   typedef struct packed {
      action_type  action;
      logic [13:0] target;
      logic [31:0] word;
      logic [9:0]  itop;
      logic [9:0]  top;
      logic [10:0] tops;
      logic        dbf;
      logic        mark;
      logic        err;
      logic [15:0] cycle;
      logic [1:0]  mode;
      logic [31:0] mask;
   } outcome_type;

   // Predicted decoder registers and the configuration they run under.
   logic        unit_full;
   logic        errors_masked;
   logic [6:0]  pend_op;
   logic [18:0] words_left;
   logic [13:0] xfer_addr;
   logic [9:0]  base_val;
   logic [9:0]  offset_val;
   logic [10:0] tops_val;
   logic [9:0]  itops_val;
   logic [9:0]  itop_val;
   logic [9:0]  top_val;
   logic        dbf;
   logic        mark_seen;
   logic        err_seen;
   logic [15:0] cycle_val;
   logic [1:0]  mode_val;
   logic [31:0] mask_val;

   outcome_type decoded_words[$];
   outcome_type want;

   // Micro memory wraps at its full size on the full unit and at 4 KiB on the small one.
   function automatic logic [13:0] micro_addr_mask();
      return unit_full ? 14'(MICRO_MEM_BYTES - 1) : SMALL_ADDR_MASK;
   endfunction

   // Starting or continuing the micro unit: itop is loaded, and the full unit swaps buffers.
   function automatic void start_micro();
      if (!unit_full) begin
         itops_val = {2'b00, itops_val[7:0]};
      end
      itop_val = itops_val;
      if (unit_full) begin
         top_val = tops_val[9:0];
         if (dbf) begin
            tops_val = {1'b0, base_val};
            dbf = 1'b0;
         end else begin
            tops_val = {1'b0, base_val} + {1'b0, offset_val};
            dbf = 1'b1;
         end
      end
   endfunction

   // Decodes one request against the predicted registers and returns its result.
   function automatic outcome_type decode_word(logic kind, logic [6:0] cmd, logic [7:0] cnt,
                                               logic [15:0] imm, logic [31:0] dat);
      outcome_type o;
      logic unknown;
      o = '0;
      unknown = 1'b0;
      if (kind) begin
         // A data word only does something while a transfer is pending.
         if (words_left != 0) begin
            case (pend_op)
               CMD_MPG: begin
                  o.action = ACT_MICRO;
                  o.target = xfer_addr;
                  o.word = dat;
                  xfer_addr = (xfer_addr + 14'd4) & micro_addr_mask();
               end
               CMD_DIRECT, CMD_DIRECTHL: begin
                  o.action = ACT_GIF;
                  o.word = dat;
               end
               CMD_STROW, CMD_STCOL: begin
                  o.action = (pend_op == CMD_STROW) ? ACT_ROW : ACT_COL;
                  o.target = {12'd0, xfer_addr[1:0]};
                  o.word = dat;
                  xfer_addr = {12'd0, xfer_addr[1:0] + 2'd1};
               end
               default: begin
                  mask_val = dat;
               end
            endcase
            words_left = words_left - 19'd1;
            if (words_left == 0) begin
               pend_op = CMD_NOP;
            end
         end
      end else begin
         // A code word always drops whatever transfer was still pending.
         pend_op = CMD_NOP;
         words_left = '0;
         case (cmd)
            CMD_NOP: ;
            CMD_STCYCL: cycle_val = imm;
            CMD_OFFSET: begin
               if (!unit_full) begin
                  unknown = 1'b1;
               end else begin
                  dbf = 1'b0;
                  offset_val = imm[9:0];
                  tops_val = {1'b0, base_val};
               end
            end
            CMD_BASE: begin
               if (!unit_full) begin
                  unknown = 1'b1;
               end else begin
                  base_val = imm[9:0];
               end
            end
            CMD_ITOP: itops_val = imm[9:0];
            CMD_STMOD: mode_val = imm[1:0];
            CMD_MSKPATH3: begin
               if (!unit_full) begin
                  unknown = 1'b1;
               end else begin
                  o.action = ACT_PATH3;
                  o.word = {31'd0, imm[15]};
               end
            end
            CMD_MARK: begin
               mark_seen = 1'b1;
               o.word = {16'd0, imm};
            end
            CMD_FLUSHE: o.action = ACT_FLUSH;
            CMD_FLUSH, CMD_FLUSHA: begin
               if (!unit_full) begin
                  unknown = 1'b1;
               end else begin
                  o.action = ACT_FLUSH;
               end
            end
            CMD_MSCAL, CMD_MSCALF: begin
               start_micro();
               o.action = ACT_START;
               o.target = {imm[10:0], 3'b000};
            end
            CMD_MSCNT: begin
               start_micro();
               o.action = ACT_CONTINUE;
            end
            CMD_STMASK: begin
               pend_op = cmd;
               words_left = MASK_WORDS;
            end
            CMD_STROW, CMD_STCOL: begin
               pend_op = cmd;
               words_left = ROWCOL_WORDS;
               xfer_addr = '0;
            end
            CMD_MPG: begin
               pend_op = cmd;
               words_left = (cnt == 0) ? MPG_WORDS_MAX : {10'd0, cnt, 1'b0};
               xfer_addr = {imm[10:0], 3'b000} & micro_addr_mask();
            end
            CMD_DIRECT, CMD_DIRECTHL: begin
               if (!unit_full) begin
                  unknown = 1'b1;
               end else begin
                  pend_op = cmd;
                  words_left = (imm == 0) ? DIRECT_WORDS_MAX : {1'b0, imm, 2'b00};
               end
            end
            default: begin
               // The top quarter of the opcode space is unpack, apart from three gaps.
               if (cmd[6:5] == 2'b11 && cmd != CMD_UNPK_GAP0 && cmd != CMD_UNPK_GAP1 &&
                   cmd != CMD_UNPK_GAP2) begin
                  o.action = ACT_UNPACK;
                  o.word = {1'b0, cmd, cnt, imm};
               end else begin
                  unknown = 1'b1;
               end
            end
         endcase
         if (unknown && !errors_masked) begin
            err_seen = 1'b1;
            o.action = ACT_ERROR;
         end
      end
      o.itop = itop_val;
      o.top = top_val;
      o.tops = tops_val;
      o.dbf = dbf;
      o.mark = mark_seen;
      o.err = err_seen;
      o.cycle = cycle_val;
      o.mode = mode_val;
      o.mask = mask_val;
      return o;
   endfunction

   // Prints one mismatch line and counts it.
   task automatic report_mismatch(input string msg);
      $display("MISMATCH: %s", msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] expected);
      if (got !== expected) begin
         report_mismatch($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
                                   results_checked, name, got, expected));
      end
   endtask

   // Results are compared before the request of the same edge is decoded: a result can
   // never belong to a request accepted at that very edge.
   always @(posedge clock) begin
      if (reset) begin
         unit_full = 1'b1;
         errors_masked = 1'b0;
         pend_op = CMD_NOP;
         words_left = '0;
         xfer_addr = '0;
         base_val = '0;
         offset_val = '0;
         tops_val = '0;
         itops_val = '0;
         itop_val = '0;
         top_val = '0;
         dbf = 1'b0;
         mark_seen = 1'b0;
         err_seen = 1'b0;
         cycle_val = '0;
         mode_val = '0;
         mask_val = '0;
         decoded_words.delete();
         mismatch_count = 0;
         results_checked = 0;
         action_seen = '0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_UNIT_SELECT: unit_full = csr_write_data;
               CSR_MASK_ERRORS: errors_masked = csr_write_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            if (decoded_words.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with no request awaiting it",
                                         results_checked));
            end else begin
               want = decoded_words.pop_front();
               action_seen[want.action] = 1'b1;
               check_field("action", rsp_action, want.action);
               check_field("target_address", rsp_target_address, want.target);
               check_field("out_word", rsp_out_word, want.word);
               check_field("itop_now", rsp_itop_now, want.itop);
               check_field("top_now", rsp_top_now, want.top);
               check_field("tops_now", rsp_tops_now, want.tops);
               check_field("buffer_flag", rsp_buffer_flag, want.dbf);
               check_field("mark_flag", rsp_mark_flag, want.mark);
               check_field("error_flag", rsp_error_flag, want.err);
               check_field("cycle_setting", rsp_cycle_setting, want.cycle);
               check_field("mode_setting", rsp_mode_setting, want.mode);
               check_field("mask_setting", rsp_mask_setting, want.mask);
            end
         end
         if (req_valid && !req_stall) begin
            decoded_words.push_back(decode_word(req_item_kind, req_command, req_count_field,
                                                req_immediate, req_data_word));
         end
      end
      results_pending = decoded_words.size();
   end

endmodule

@@ test/tb_vector_interface_command_decoder_unit.sv @@
`timescale 1ns / 1ps
// Testbench top for the vector interface command decoder: clock, reset, request and
// register stimulus, result back-pressure and the verdict. Depends on vicd_pkg,
// the decoder RTL and tb_vicd_checker, which does all prediction and comparison.
module tb_vector_interface_command_decoder_unit;
   import vicd_pkg::*;

   localparam int MEM_BYTES = 16384;
   localparam int LONG_HOLD = 60;
   localparam int RANDOM_ITEMS = 350;
   localparam int PHASES = 6;
   // One unpack format code, used to show the hand-off.
   localparam logic [6:0] UNPACK_V4_32 = 7'h6c;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic        csr_index;
   logic        csr_write_data;
   logic        req_valid;
   logic        req_stall;
   logic        req_item_kind;
   logic [6:0]  req_command;
   logic [7:0]  req_count_field;
   logic [15:0] req_immediate;
   logic [31:0] req_data_word;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [3:0]  rsp_action;
   logic [13:0] rsp_target_address;
   logic [31:0] rsp_out_word;
   logic [9:0]  rsp_itop_now;
   logic [9:0]  rsp_top_now;
   logic [10:0] rsp_tops_now;
   logic        rsp_buffer_flag;
   logic        rsp_mark_flag;
   logic        rsp_error_flag;
   logic [15:0] rsp_cycle_setting;
   logic [1:0]  rsp_mode_setting;
   logic [31:0] rsp_mask_setting;

   int          mismatch_count;
   int          results_pending;
   int          results_checked;
   logic [15:0] action_seen;

   int   sent_count = 0;
   int   useful_items = 0;
   int   phase_count = 0;
   int   sender_burst = 0;
   int   recv_burst = 0;
   logic hold_off_request = 1'b0;

   // Commands that the random part builds well-formed sequences from.
   localparam logic [6:0] WELL_FORMED [20] = '{
      CMD_NOP, CMD_STCYCL, CMD_OFFSET, CMD_BASE, CMD_ITOP, CMD_STMOD, CMD_MSKPATH3,
      CMD_MARK, CMD_FLUSHE, CMD_FLUSH, CMD_FLUSHA, CMD_MSCAL, CMD_MSCALF, CMD_MSCNT,
      CMD_STMASK, CMD_STROW, CMD_STCOL, CMD_MPG, CMD_DIRECT, CMD_DIRECTHL
   };

   vector_interface_command_decoder_unit #(.MICRO_MEM_BYTES(MEM_BYTES)) dut (.*);

   tb_vicd_checker #(.MICRO_MEM_BYTES(MEM_BYTES)) checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // A hard limit on the run in case the block stops answering.
   initial begin
      #5_000_000;
      $display("Run timed out with %0d results still awaited.", results_pending);
      $display("RESULT: ERROR");
      $finish;
   end

   // Offers one request after a random gap and holds it until it is accepted.
   task automatic send_item(input logic kind, input logic [6:0] cmd, input logic [7:0] cnt,
                            input logic [15:0] imm, input logic [31:0] dat);
      int gap;
      if (sender_burst > 0) begin
         gap = 0;
         sender_burst--;
      end else if ($urandom_range(0, 15) == 0) begin
         sender_burst = $urandom_range(10, 30);
         gap = 0;
      end else begin
         gap = $urandom_range(0, 13);
      end
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_item_kind = kind;
      req_command = cmd;
      req_count_field = cnt;
      req_immediate = imm;
      req_data_word = dat;
      do @(posedge clock); while (req_stall);
      sent_count++;
   endtask

   // Code words carry a random data field, data words random code fields.
   task automatic send_code(input logic [6:0] cmd, input logic [7:0] cnt,
                            input logic [15:0] imm);
      useful_items++;
      send_item(1'b0, cmd, cnt, imm, $urandom);
   endtask

   task automatic send_data(input logic [31:0] dat);
      useful_items++;
      send_item(1'b1, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                16'($urandom_range(0, 65535)), dat);
   endtask

   // Lets every outstanding request drain before the registers may change.
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (results_pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic configure(input logic unit, input logic mask);
      csr_write_enable = 1'b1;
      csr_index = CSR_UNIT_SELECT;
      csr_write_data = unit;
      @(negedge clock);
      csr_index = CSR_MASK_ERRORS;
      csr_write_data = mask;
      @(negedge clock);
      csr_write_enable = 1'b0;
      phase_count++;
   endtask

   // Mostly complete command sequences with random content, some cut short or padded,
   // plus stray data words and arbitrary opcodes.
   task automatic random_sequence();
      int pick;
      int words;
      logic [6:0] op;
      logic [7:0] cnt;
      logic [15:0] imm;
      pick = $urandom_range(0, 99);
      words = 0;
      if (pick < 6) begin
         send_item(1'b1, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                   16'($urandom_range(0, 65535)), $urandom);
      end else if (pick < 16) begin
         send_code(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                   16'($urandom_range(0, 65535)));
      end else begin
         op = WELL_FORMED[$urandom_range(0, 19)];
         cnt = 8'($urandom_range(0, 255));
         imm = 16'($urandom_range(0, 65535));
         case (op)
            CMD_MPG: begin
               if ($urandom_range(0, 5) != 0) begin
                  cnt = 8'($urandom_range(1, 3));
               end
               words = (cnt == 0) ? 8 : ((cnt > 4) ? 8 : 2 * cnt);
            end
            CMD_DIRECT, CMD_DIRECTHL: begin
               if ($urandom_range(0, 5) != 0) begin
                  imm = 16'($urandom_range(1, 2));
               end
               words = (imm == 0 || imm > 2) ? 8 : 4 * imm;
            end
            CMD_STROW, CMD_STCOL: words = 4;
            CMD_STMASK: words = 1;
            default: words = 0;
         endcase
         if (words > 0 && $urandom_range(0, 7) == 0) begin
            words = $urandom_range(0, words - 1);
         end else if ($urandom_range(0, 9) == 0) begin
            words++;
         end
         send_code(op, cnt, imm);
         repeat (words) send_data($urandom);
      end
   endtask

   // Result side: a random stall per result, stretches without stalls, and one long hold.
   initial begin
      int n;
      rsp_stall = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            n = LONG_HOLD;
            hold_off_request = 1'b0;
         end else if (recv_burst > 0) begin
            n = 0;
            recv_burst--;
         end else if ($urandom_range(0, 15) == 0) begin
            recv_burst = $urandom_range(10, 30);
            n = 0;
         end else begin
            n = $urandom_range(0, 13);
         end
         if (n > 0) begin
            rsp_stall = 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall = 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Request side and verdict.
   initial begin
      int goal;
      int i;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = CSR_UNIT_SELECT;
      csr_write_data = 1'b0;
      req_valid = 1'b0;
      req_item_kind = 1'b0;
      req_command = CMD_NOP;
      req_count_field = '0;
      req_immediate = '0;
      req_data_word = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part on the reset configuration: every command but DIRECTHL, with field extremes.
      send_code(CMD_NOP, 8'hff, 16'hffff);
      send_code(CMD_STCYCL, 8'h00, 16'hffff);
      send_code(CMD_STMOD, 8'h00, 16'h0003);
      send_code(CMD_BASE, 8'h00, 16'hffff);
      send_code(CMD_OFFSET, 8'h00, 16'h0155);
      send_code(CMD_ITOP, 8'h00, 16'hffff);
      send_code(CMD_MSCAL, 8'h00, 16'hffff);
      send_code(CMD_MSCALF, 8'h00, 16'h0000);
      send_code(CMD_MSCNT, 8'h00, 16'h0000);
      send_code(CMD_MARK, 8'h00, 16'ha5a5);
      send_code(CMD_MSKPATH3, 8'h00, 16'h8000);
      send_code(CMD_FLUSHE, 8'h00, 16'h0000);
      send_code(CMD_FLUSH, 8'h00, 16'h0000);
      send_code(CMD_FLUSHA, 8'h00, 16'h0000);
      send_code(CMD_STMASK, 8'h00, 16'h0000);
      send_data(32'hffff_ffff);
      // A full row load followed by a data word with nothing pending.
      send_code(CMD_STROW, 8'h00, 16'h0000);
      repeat (5) send_data($urandom);
      // A column load cut short by a new command.
      send_code(CMD_STCOL, 8'h00, 16'h0000);
      repeat (2) send_data($urandom);
      send_code(CMD_DIRECT, 8'h00, 16'h0000);
      send_data(32'h0000_0000);
      send_code(UNPACK_V4_32, 8'hff, 16'hffff);
      // A program upload that runs off the top of micro memory.
      send_code(CMD_MPG, 8'd2, 16'h07ff);
      repeat (3) send_data($urandom);
      // A long upload that carries on after the unit is switched to the small one.
      send_code(CMD_MPG, 8'd0, 16'h05ff);
      repeat (2) send_data($urandom);
      settle();
      configure(1'b0, 1'b0);
      repeat (2) send_data($urandom);
      // Itops set above the small unit's range, then a full-unit-only command.
      send_code(CMD_MSCNT, 8'h00, 16'h0000);
      send_code(CMD_BASE, 8'h00, 16'h0001);
      send_code(CMD_UNPK_GAP1, 8'h00, 16'h0000);

      // Random part over several register settings, the extremes first.
      for (i = 0; i < PHASES; i++) begin
         settle();
         case (i)
            0: configure(1'b0, 1'b1);
            1: configure(1'b1, 1'b1);
            2: configure(1'b1, 1'b0);
            3: configure(1'b0, 1'b0);
            default: configure(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         endcase
         if (i == 1) begin
            // Hold results back while requests keep coming, so the input side stalls.
            hold_off_request = 1'b1;
            sender_burst = 40;
         end
         goal = useful_items + RANDOM_ITEMS / PHASES;
         while (useful_items < goal) random_sequence();
      end

      @(negedge clock);
      req_valid = 1'b0;
      for (i = 0; i < 3000 && results_pending != 0; i++) @(negedge clock);
      repeat (4) @(negedge clock);
      if (results_pending != 0) begin
         $display("%0d expected results never arrived.", results_pending);
      end
      $display("Sent %0d requests over %0d register settings, including a long result hold.",
               sent_count, phase_count);
      $display("Compared %0d results field by field, covering %0d of 11 action codes.",
               results_checked, $countones(action_seen));
      if (mismatch_count == 0 && results_pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
